@@ rtl/core/aluf_pkg.sv @@
// types and constants shared by the alu flags and relative jumps unit
// no dependencies
`timescale 1ns / 1ps

package aluf_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned OffW  = 10;

  typedef enum logic [3:0] {
    KIND_MOV = 4'd0,
    KIND_ADD = 4'd1,
    KIND_SUB = 4'd2,
    KIND_CMP = 4'd3,
    KIND_BIC = 4'd4,
    KIND_BIS = 4'd5,
    KIND_XOR = 4'd6,
    KIND_AND = 4'd7,
    KIND_JNE = 4'd8,
    KIND_JEQ = 4'd9,
    KIND_JNC = 4'd10,
    KIND_JC  = 4'd11,
    KIND_JN  = 4'd12,
    KIND_JGE = 4'd13,
    KIND_JL  = 4'd14,
    KIND_JMP = 4'd15
  } kind_e;

  // packed so that bit0 is carry, bit3 is overflow
  typedef struct packed {
    logic v;
    logic n;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             write_back;
    flags_t           flags;
  } alu_res_t;

  typedef struct packed {
    logic             taken;
    logic [WordW-1:0] next_pc;
  } branch_res_t;

endpackage

@@ rtl/core/alu_flags_and_relative_jumps_unit.sv @@
// top level: input register, alu and branch logic, flags register, result register
// depends on aluf_pkg, aluf_alu, aluf_branch
`timescale 1ns / 1ps

// Executes one 16-bit instruction per word: mov, add, sub, cmp, bic, bis, xor, and,
// and eight relative jumps, all but jmp tested on the stored carry, zero, negative and
// overflow flags. An accepted word sits in an input register, passes through one
// 16-bit adder and the flag and branch logic, and lands in the result register
// as it leaves the input register, when the status flags update too, so a word
// may be accepted every cycle while out_ready_i stays high and a following word
// sees the flags of the one before it. The result register keeps its word while
// out_ready_i is low and the input register still takes one more word. Reset
// clears the flags.

module alu_flags_and_relative_jumps_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [3:0]                          kind_i,
  input  logic [aluf_pkg::WordW-1:0]          src_value_i,
  input  logic [aluf_pkg::WordW-1:0]          dst_value_i,
  input  logic [aluf_pkg::WordW-1:0]          pc_value_i,
  input  logic signed [aluf_pkg::OffW-1:0]    jump_offset_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [aluf_pkg::WordW-1:0]          result_value_o,
  output logic                                write_back_o,
  output logic [3:0]                          flags_out_o,
  output logic                                branch_taken_o,
  output logic [aluf_pkg::WordW-1:0]          next_pc_o
);

  localparam int unsigned W = aluf_pkg::WordW;
  localparam int unsigned O = aluf_pkg::OffW;

  logic                  in_vld_q;
  aluf_pkg::kind_e       kind_q;
  logic [W-1:0]          src_q;
  logic [W-1:0]          dst_q;
  logic [W-1:0]          pc_q;
  logic signed [O-1:0]   off_q;

  aluf_pkg::flags_t      flags_q, flags_d;
  aluf_pkg::alu_res_t    alu_res;
  aluf_pkg::branch_res_t br_res;

  logic                  out_vld_q;
  logic [W-1:0]          result_q;
  logic                  wb_q;
  logic [3:0]            flags_out_q;
  logic                  taken_q;
  logic [W-1:0]          npc_q;

  logic                  out_free;
  logic                  advance;
  logic                  accept;

  assign out_free   = ~out_vld_q | out_ready_i;
  assign advance    = in_vld_q & out_free;
  assign in_ready_o = ~in_vld_q | out_free;
  assign accept     = in_valid_i & in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= aluf_pkg::kind_e'(kind_i);
      src_q  <= src_value_i;
      dst_q  <= dst_value_i;
      pc_q   <= pc_value_i;
      off_q  <= jump_offset_i;
    end
  end

  aluf_alu u_alu (
    .kind_i  (kind_q),
    .src_i   (src_q),
    .dst_i   (dst_q),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  aluf_branch u_branch (
    .kind_i   (kind_q),
    .pc_i     (pc_q),
    .offset_i (off_q),
    .flags_i  (flags_q),
    .res_o    (br_res)
  );

  assign flags_d = advance ? alu_res.flags : flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q    <= alu_res.result;
      wb_q        <= alu_res.write_back;
      flags_out_q <= alu_res.flags;
      taken_q     <= br_res.taken;
      npc_q       <= br_res.next_pc;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_value_o = result_q;
  assign write_back_o   = wb_q;
  assign flags_out_o    = flags_out_q;
  assign branch_taken_o = taken_q;
  assign next_pc_o      = npc_q;

  // flags only move when a word passes to the result register
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without a word passing");

  // a delivered word carries the flags that are now stored
  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (flags_out_o == flags_q))
    else $error("reported flags differ from stored flags");

  // a word never both writes back and takes a jump
  a_wb_xor_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_back_o && branch_taken_o))
    else $error("write-back and taken jump on one word");

  // an accepted word always occupies the input register next cycle
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_vld_q)
    else $error("accepted word lost");

endmodule

@@ rtl/core/aluf_alu.sv @@
// data path of the unit: two-operand operations and their status flags
// depends on aluf_pkg
`timescale 1ns / 1ps

module aluf_alu (
  input  aluf_pkg::kind_e                kind_i,
  input  logic [aluf_pkg::WordW-1:0]     src_i,
  input  logic [aluf_pkg::WordW-1:0]     dst_i,
  input  aluf_pkg::flags_t               flags_i,
  output aluf_pkg::alu_res_t             res_o
);

  localparam int unsigned W = aluf_pkg::WordW;

  logic          is_sub;
  logic [W-1:0]  opb;
  logic [W:0]    sum;
  logic [W-1:0]  r;
  logic [W-1:0]  logic_r;

  // one adder serves add, sub and cmp; subtract is dst + ~src + 1
  assign is_sub = (kind_i == aluf_pkg::KIND_SUB) || (kind_i == aluf_pkg::KIND_CMP);
  assign opb    = is_sub ? ~src_i : src_i;
  assign sum    = {1'b0, dst_i} + {1'b0, opb} + {{W{1'b0}}, is_sub};
  assign r      = sum[W-1:0];

  always_comb begin
    logic_r = '0;
    case (kind_i)
      aluf_pkg::KIND_MOV: logic_r = src_i;
      aluf_pkg::KIND_BIC: logic_r = dst_i & ~src_i;
      aluf_pkg::KIND_BIS: logic_r = dst_i | src_i;
      aluf_pkg::KIND_XOR: logic_r = dst_i ^ src_i;
      aluf_pkg::KIND_AND: logic_r = dst_i & src_i;
      default:            logic_r = '0;
    endcase
  end

  always_comb begin
    res_o.result     = '0;
    res_o.write_back = 1'b0;
    res_o.flags      = flags_i;
    case (kind_i)
      aluf_pkg::KIND_ADD: begin
        res_o.result     = r;
        res_o.write_back = 1'b1;
        res_o.flags.c    = sum[W];
        res_o.flags.z    = (r == '0);
        res_o.flags.n    = r[W-1];
        res_o.flags.v    = (dst_i[W-1] ^ r[W-1]) & (src_i[W-1] ^ r[W-1]);
      end
      aluf_pkg::KIND_SUB, aluf_pkg::KIND_CMP: begin
        res_o.result     = r;
        res_o.write_back = (kind_i == aluf_pkg::KIND_SUB);
        res_o.flags.c    = sum[W];
        res_o.flags.z    = (r == '0);
        res_o.flags.n    = r[W-1];
        res_o.flags.v    = (dst_i[W-1] ^ src_i[W-1]) & (dst_i[W-1] ^ r[W-1]);
      end
      aluf_pkg::KIND_MOV, aluf_pkg::KIND_BIC, aluf_pkg::KIND_BIS: begin
        res_o.result     = logic_r;
        res_o.write_back = 1'b1;
      end
      aluf_pkg::KIND_XOR, aluf_pkg::KIND_AND: begin
        res_o.result     = logic_r;
        res_o.write_back = 1'b1;
        res_o.flags.c    = (logic_r != '0);
        res_o.flags.z    = (logic_r == '0);
        res_o.flags.n    = logic_r[W-1];
        // xor sets overflow when both operands are negative, and clears it
        res_o.flags.v    = (kind_i == aluf_pkg::KIND_XOR) & dst_i[W-1] & src_i[W-1];
      end
      default: begin
        // jumps: no result word, flags kept
        res_o.result     = '0;
        res_o.write_back = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/aluf_branch.sv @@
// jump condition test on the stored flags and relative target calculation
// depends on aluf_pkg
`timescale 1ns / 1ps

module aluf_branch (
  input  aluf_pkg::kind_e                  kind_i,
  input  logic [aluf_pkg::WordW-1:0]       pc_i,
  input  logic signed [aluf_pkg::OffW-1:0] offset_i,
  input  aluf_pkg::flags_t                 flags_i,
  output aluf_pkg::branch_res_t            res_o
);

  localparam int unsigned W = aluf_pkg::WordW;
  localparam int unsigned O = aluf_pkg::OffW;

  logic         cond;
  logic [W-1:0] disp;

  // twice the sign-extended word offset
  assign disp = {{(W-O-1){offset_i[O-1]}}, offset_i, 1'b0};

  always_comb begin
    cond = 1'b0;
    case (kind_i)
      aluf_pkg::KIND_JNE: cond = ~flags_i.z;
      aluf_pkg::KIND_JEQ: cond = flags_i.z;
      aluf_pkg::KIND_JNC: cond = ~flags_i.c;
      aluf_pkg::KIND_JC:  cond = flags_i.c;
      aluf_pkg::KIND_JN:  cond = flags_i.n;
      aluf_pkg::KIND_JGE: cond = ~(flags_i.n ^ flags_i.v);
      aluf_pkg::KIND_JL:  cond = flags_i.n ^ flags_i.v;
      aluf_pkg::KIND_JMP: cond = 1'b1;
      default:            cond = 1'b0;
    endcase
  end

  assign res_o.taken   = cond;
  assign res_o.next_pc = cond ? (pc_i + disp) : pc_i;

endmodule

@@ tb/aluf_checker.sv @@
// checker for the alu flags and relative jumps unit: watches both channels,
// predicts each result word from its own copy of the status flags and compares
// depends on aluf_pkg
`timescale 1ns / 1ps

module aluf_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [3:0]                 kind_i,
  input  logic [aluf_pkg::WordW-1:0] src_value_i,
  input  logic [aluf_pkg::WordW-1:0] dst_value_i,
  input  logic [aluf_pkg::WordW-1:0] pc_value_i,
  input  logic [aluf_pkg::OffW-1:0]  jump_offset_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [aluf_pkg::WordW-1:0] result_value_i,
  input  logic                       write_back_i,
  input  logic [3:0]                 flags_out_i,
  input  logic                       branch_taken_i,
  input  logic [aluf_pkg::WordW-1:0] next_pc_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o
);

  localparam int unsigned WordW = aluf_pkg::WordW;
  localparam int unsigned OffW  = aluf_pkg::OffW;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             write_back;
    aluf_pkg::flags_t flags;
    logic             taken;
    logic [WordW-1:0] next_pc;
  } exec_word_t;

  exec_word_t       expected_q[$];
  aluf_pkg::flags_t status_flags = '0;
  int unsigned      mismatches = 0;

  // executes one instruction against the current flags; the new flags ride in the word
  function automatic exec_word_t execute_word(input aluf_pkg::kind_e op,
                                              input logic [WordW-1:0] src,
                                              input logic [WordW-1:0] dst,
                                              input logic [WordW-1:0] pc,
                                              input logic [OffW-1:0] off,
                                              input aluf_pkg::flags_t st);
    exec_word_t w;
    logic [WordW:0] sum;
    logic [WordW-1:0] r;
    logic hit;
    w = '0;
    w.flags = st;
    w.next_pc = pc;
    r = '0;
    case (op)
      aluf_pkg::KIND_MOV: begin
        r = src;
        w.write_back = 1'b1;
      end
      aluf_pkg::KIND_ADD: begin
        sum = {1'b0, dst} + {1'b0, src};
        r = sum[WordW-1:0];
        w.write_back = 1'b1;
        w.flags.c = sum[WordW];
        w.flags.z = (r == '0);
        w.flags.n = r[WordW-1];
        w.flags.v = (dst[WordW-1] == src[WordW-1]) && (r[WordW-1] != dst[WordW-1]);
      end
      aluf_pkg::KIND_SUB, aluf_pkg::KIND_CMP: begin
        // carry set means no borrow
        sum = {1'b0, dst} + {1'b0, ~src} + 17'd1;
        r = sum[WordW-1:0];
        w.write_back = (op == aluf_pkg::KIND_SUB);
        w.flags.c = sum[WordW];
        w.flags.z = (r == '0);
        w.flags.n = r[WordW-1];
        w.flags.v = (dst[WordW-1] != src[WordW-1]) && (r[WordW-1] != dst[WordW-1]);
      end
      aluf_pkg::KIND_BIC: begin
        r = dst & ~src;
        w.write_back = 1'b1;
      end
      aluf_pkg::KIND_BIS: begin
        r = dst | src;
        w.write_back = 1'b1;
      end
      aluf_pkg::KIND_XOR: begin
        r = dst ^ src;
        w.write_back = 1'b1;
        w.flags.z = (r == '0);
        w.flags.n = r[WordW-1];
        w.flags.c = (r != '0);
        w.flags.v = dst[WordW-1] & src[WordW-1];
      end
      aluf_pkg::KIND_AND: begin
        r = dst & src;
        w.write_back = 1'b1;
        w.flags.z = (r == '0);
        w.flags.n = r[WordW-1];
        w.flags.c = (r != '0);
        w.flags.v = 1'b0;
      end
      default: begin
        case (op)
          aluf_pkg::KIND_JNE: hit = !st.z;
          aluf_pkg::KIND_JEQ: hit = st.z;
          aluf_pkg::KIND_JNC: hit = !st.c;
          aluf_pkg::KIND_JC:  hit = st.c;
          aluf_pkg::KIND_JN:  hit = st.n;
          aluf_pkg::KIND_JGE: hit = (st.n == st.v);
          aluf_pkg::KIND_JL:  hit = (st.n != st.v);
          default:            hit = 1'b1;
        endcase
        if (hit) begin
          w.taken = 1'b1;
          w.next_pc = pc + {{(WordW-OffW-1){off[OffW-1]}}, off, 1'b0};
        end
      end
    endcase
    w.result = r;
    return w;
  endfunction

  function automatic int unsigned check_field(input string name, input logic [WordW-1:0] want,
                                              input logic [WordW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    exec_word_t want;
    if (!rst_ni) begin
      status_flags = '0;
      expected_q.delete();
    end else begin
      // retire before predicting so a word accepted this edge is never compared now
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result word with no instruction outstanding");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += check_field("result_value", want.result, result_value_i);
          mismatches += check_field("write_back", {15'd0, want.write_back}, {15'd0, write_back_i});
          mismatches += check_field("flags_out", {12'd0, want.flags}, {12'd0, flags_out_i});
          mismatches += check_field("branch_taken", {15'd0, want.taken}, {15'd0, branch_taken_i});
          mismatches += check_field("next_pc", want.next_pc, next_pc_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = execute_word(aluf_pkg::kind_e'(kind_i), src_value_i, dst_value_i, pc_value_i,
                            jump_offset_i, status_flags);
        status_flags = want.flags;
        expected_q.push_back(want);
      end
    end
    errors_o  <= mismatches;
    pending_o <= expected_q.size();
  end

endmodule

@@ tb/alu_flags_and_relative_jumps_unit_tb.sv @@
// testbench top for the alu flags and relative jumps unit: clock, reset, stimulus
// and verdict; prediction and comparison live in aluf_checker
// depends on aluf_pkg, aluf_checker and the unit itself
`timescale 1ns / 1ps

module alu_flags_and_relative_jumps_unit_tb;

  localparam int unsigned WordW = aluf_pkg::WordW;
  localparam int unsigned OffW  = aluf_pkg::OffW;
  localparam int unsigned NumRandom = 1500;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [3:0]              kind = '0;
  logic [WordW-1:0]        src_value = '0;
  logic [WordW-1:0]        dst_value = '0;
  logic [WordW-1:0]        pc_value = '0;
  logic signed [OffW-1:0]  jump_offset = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [WordW-1:0]        result_value;
  logic                    write_back;
  logic [3:0]              flags_out;
  logic                    branch_taken;
  logic [WordW-1:0]        next_pc;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  logic        quiet = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  alu_flags_and_relative_jumps_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (kind),
    .src_value_i    (src_value),
    .dst_value_i    (dst_value),
    .pc_value_i     (pc_value),
    .jump_offset_i  (jump_offset),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_o (result_value),
    .write_back_o   (write_back),
    .flags_out_o    (flags_out),
    .branch_taken_o (branch_taken),
    .next_pc_o      (next_pc)
  );

  aluf_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .kind_i         (kind),
    .src_value_i    (src_value),
    .dst_value_i    (dst_value),
    .pc_value_i     (pc_value),
    .jump_offset_i  (jump_offset),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_value_i (result_value),
    .write_back_i   (write_back),
    .flags_out_i    (flags_out),
    .branch_taken_i (branch_taken),
    .next_pc_i      (next_pc),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  function automatic logic take_gap();
    return !quiet && ($urandom_range(99) < 9);
  endfunction

  // corner values often, so carry, zero, negative and overflow all toggle
  function automatic logic [WordW-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'h0001;
      default: return WordW'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ready <= !take_gap();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("alu_flags_and_relative_jumps_unit test failed");
      $finish;
    end
  end

  task automatic send_word(input aluf_pkg::kind_e op, input logic [WordW-1:0] src,
                           input logic [WordW-1:0] dst, input logic [WordW-1:0] pc,
                           input logic [OffW-1:0] off);
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    kind        <= op;
    src_value   <= src;
    dst_value   <= dst;
    pc_value    <= pc;
    jump_offset <= off;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  initial begin
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [OffW-1:0]  off;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: flag extremes, with jumps taken and not taken on the flags they leave
    send_word(aluf_pkg::KIND_MOV, 16'hFFFF, 16'h0000, 16'h1234, 10'h000);
    send_word(aluf_pkg::KIND_ADD, 16'h0001, 16'hFFFF, 16'h0000, 10'h3FF);  // carry out, zero
    send_word(aluf_pkg::KIND_JNE, 16'h0000, 16'h0000, 16'h0100, 10'h010);
    send_word(aluf_pkg::KIND_JEQ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h1FF);  // target wraps up
    send_word(aluf_pkg::KIND_ADD, 16'h0001, 16'h7FFF, 16'h0000, 10'h000);  // signed overflow
    send_word(aluf_pkg::KIND_JGE, 16'h0000, 16'h0000, 16'h0000, 10'h200);  // target wraps down
    send_word(aluf_pkg::KIND_JL,  16'h0000, 16'h0000, 16'h0200, 10'h001);
    send_word(aluf_pkg::KIND_SUB, 16'h0001, 16'h0000, 16'h0000, 10'h000);  // borrow
    send_word(aluf_pkg::KIND_JNC, 16'h5555, 16'hAAAA, 16'h4000, 10'h155);
    send_word(aluf_pkg::KIND_JC,  16'h0000, 16'h0000, 16'h4000, 10'h2AA);
    send_word(aluf_pkg::KIND_JN,  16'h0000, 16'h0000, 16'h8000, 10'h3FF);
    send_word(aluf_pkg::KIND_JL,  16'h0000, 16'h0000, 16'h8000, 10'h200);
    send_word(aluf_pkg::KIND_CMP, 16'h0001, 16'h8000, 16'h0000, 10'h000);  // no write-back
    send_word(aluf_pkg::KIND_JC,  16'h0000, 16'h0000, 16'h0010, 10'h1FF);
    send_word(aluf_pkg::KIND_JN,  16'h0000, 16'h0000, 16'h0010, 10'h1FF);
    send_word(aluf_pkg::KIND_JGE, 16'h0000, 16'h0000, 16'h0010, 10'h1FF);
    send_word(aluf_pkg::KIND_SUB, 16'h0005, 16'h0005, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_BIC, 16'h00FF, 16'hFFFF, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_BIS, 16'h0000, 16'h0000, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_XOR, 16'h8000, 16'h8000, 16'h0000, 10'h000);  // both negative
    send_word(aluf_pkg::KIND_XOR, 16'h0000, 16'hFFFF, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_AND, 16'hFFFF, 16'hFFFF, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_AND, 16'hAAAA, 16'h5555, 16'h0000, 10'h000);
    send_word(aluf_pkg::KIND_JMP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h000);
    send_word(aluf_pkg::KIND_JEQ, 16'hFFFF, 16'h0000, 16'hFFFE, 10'h3FE);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      // a stretch in the middle with no gaps on either side
      quiet = (i >= 600) && (i < 900);
      a = pick_operand();
      b = ($urandom_range(5) == 0) ? a : pick_operand();
      case ($urandom_range(3))
        0:       off = 10'h200;
        1:       off = 10'h1FF;
        default: off = OffW'($urandom);
      endcase
      send_word(aluf_pkg::kind_e'($urandom_range(15)), a, b, WordW'($urandom), off);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // let the checker count the last accepted word before waiting on it
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("alu_flags_and_relative_jumps_unit test passed");
    end else begin
      $display("alu_flags_and_relative_jumps_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/aluf_pkg.sv
rtl/core/aluf_alu.sv
rtl/core/aluf_branch.sv
rtl/core/alu_flags_and_relative_jumps_unit.sv
tb/aluf_checker.sv
tb/alu_flags_and_relative_jumps_unit_tb.sv
